[design/tgcl_pkg.sv]
// Shared types, constants and codes for the text grid cell layout block.
`default_nettype none

package tgcl_pkg;

   // Grid limits; the values of the size registers are clamped to these where they are used.
   localparam int MAX_COLS = 256;
   localparam int MAX_ROWS = 64;
   localparam int MAX_TAB  = 16;

   // Field and state widths.
   localparam int TW_W     = 5;   // tab width register
   localparam int COL_W    = 9;   // screen width register, column position, used columns
   localparam int SH_W     = 7;   // screen height register
   localparam int ROW_W    = 6;   // row position and row field
   localparam int COLUMN_W = 8;   // column field
   localparam int LINE_W   = 32;
   localparam int GLYPH_W  = 32;
   localparam int NBYTE_W  = 4;
   localparam int DW_W     = 2;
   localparam int ATTR_W   = 16;
   localparam int UBYTES_W = 12;
   localparam int TIDX_W   = 4;   // index of a tab cell within one tab
   localparam int MCNT_W   = 4;   // bit counter of the remainder unit
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   localparam logic [UBYTES_W-1:0] BYTES_MAX = 12'd4095;

   // Register reset values.
   localparam logic [TW_W-1:0] TAB_WIDTH_RESET     = 5'd8;
   localparam logic [COL_W-1:0] SCREEN_WIDTH_RESET = 9'd80;
   localparam logic [SH_W-1:0] SCREEN_HEIGHT_RESET = 7'd24;

   // Character codes.
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_CARET   = 8'h5E;
   localparam logic [7:0] CHAR_DEL     = 8'h7F;
   localparam logic [7:0] CTRL_OFFSET  = 8'd64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TAB_WIDTH     = 2'd0,
      CSR_SCREEN_WIDTH  = 2'd1,
      CSR_SCREEN_HEIGHT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ACT_WRITE    = 2'd0,
      ACT_CLEAR    = 2'd1,
      ACT_NO_SPACE = 2'd2
   } action_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_START,
      OP_NO_SPACE,
      OP_MOD_INIT,
      OP_MOD_STEP,
      OP_TAB_CELL,
      OP_NL_WRITE,
      OP_NL_END,
      OP_CH_WRAP,
      OP_CH_WRITE,
      OP_CH_PAD
   } op_type;

   typedef struct packed {
      logic                 kind;
      logic [LINE_W-1:0]    first_line_number;
      logic [GLYPH_W-1:0]   glyph;
      logic [NBYTE_W-1:0]   byte_count;
      logic [DW_W-1:0]      display_width;
      logic [ATTR_W-1:0]    attribute;
   } req_type;

   typedef struct packed {
      action_type           action;
      logic [ROW_W-1:0]     row;
      logic [COLUMN_W-1:0]  column;
      logic [GLYPH_W-1:0]   cell_glyph;
      logic [NBYTE_W-1:0]   cell_bytes;
      logic [DW_W-1:0]      cell_columns;
      logic                 tab_cell;
      logic [ATTR_W-1:0]    cell_attribute;
      logic [LINE_W-1:0]    row_line_number;
      logic [COL_W-1:0]     row_used_columns;
      logic [UBYTES_W-1:0]  row_used_bytes;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic   load_item;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic kind;
      logic full_cond;
      logic is_tab;
      logic is_nl;
      logic fits;
      logic col_lt_sw;
      logic next_ok;
      logic wrap_fail;
      logic tab_last;
      logic mod_last;
      logic nl_clear;
      logic wide;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

[design/tgcl_channels.sv]
// Request and result channel interfaces of the text grid cell layout block.
`default_nettype none

interface tgcl_req_if import tgcl_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                kind;
   logic [LINE_W-1:0]   first_line_number;
   logic [GLYPH_W-1:0]  glyph;
   logic [NBYTE_W-1:0]  byte_count;
   logic [DW_W-1:0]     display_width;
   logic [ATTR_W-1:0]   attribute;

   modport source (output valid, kind, first_line_number, glyph, byte_count,
                   display_width, attribute, input ready);
   modport sink (input valid, kind, first_line_number, glyph, byte_count,
                 display_width, attribute, output ready);
endinterface

interface tgcl_rsp_if import tgcl_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           action;
   logic [ROW_W-1:0]     row;
   logic [COLUMN_W-1:0]  column;
   logic [GLYPH_W-1:0]   cell_glyph;
   logic [NBYTE_W-1:0]   cell_bytes;
   logic [DW_W-1:0]      cell_columns;
   logic                 tab_cell;
   logic [ATTR_W-1:0]    cell_attribute;
   logic [LINE_W-1:0]    row_line_number;
   logic [COL_W-1:0]     row_used_columns;
   logic [UBYTES_W-1:0]  row_used_bytes;
   logic                 last;

   modport source (output valid, action, row, column, cell_glyph, cell_bytes,
                   cell_columns, tab_cell, cell_attribute, row_line_number,
                   row_used_columns, row_used_bytes, last, input ready);
   modport sink (input valid, action, row, column, cell_glyph, cell_bytes,
                 cell_columns, tab_cell, cell_attribute, row_line_number,
                 row_used_columns, row_used_bytes, last, output ready);
endinterface

`default_nettype wire

[design/tgcl_ctrl.sv]
// Sequencing state machine of the text grid cell layout block.
`default_nettype none

module tgcl_ctrl import tgcl_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_TAB_MOD,
      ST_TAB_CELL,
      ST_NL_WRITE,
      ST_NL_END,
      ST_CH_WRAP,
      ST_CH_WRITE,
      ST_CH_PAD,
      ST_NO_SPACE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd.load_item = 1'b0;
      cmd.op        = OP_NONE;
      req_ready     = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!status.kind) begin
               cmd.op   = OP_START;
               state_in = ST_IDLE;
            end else if (status.full_cond) begin
               if (status.out_free) begin
                  cmd.op   = OP_NO_SPACE;
                  state_in = ST_IDLE;
               end
            end else if (status.is_tab) begin
               cmd.op   = OP_MOD_INIT;
               state_in = ST_TAB_MOD;
            end else if (status.is_nl) begin
               state_in = ST_NL_WRITE;
            end else begin
               state_in = ST_CH_WRAP;
            end
         end
         ST_TAB_MOD: begin
            cmd.op = OP_MOD_STEP;
            if (status.mod_last) begin
               state_in = ST_TAB_CELL;
            end
         end
         ST_TAB_CELL: begin
            if (status.out_free) begin
               cmd.op = OP_TAB_CELL;
               if (status.wrap_fail || status.tab_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_NL_WRITE: begin
            if (status.out_free) begin
               cmd.op   = OP_NL_WRITE;
               state_in = status.wrap_fail ? ST_IDLE : ST_NL_END;
            end
         end
         ST_NL_END: begin
            if (status.out_free || !status.nl_clear) begin
               cmd.op   = OP_NL_END;
               state_in = ST_IDLE;
            end
         end
         ST_CH_WRAP: begin
            if (status.fits) begin
               state_in = ST_CH_WRITE;
            end else if (status.out_free || !status.col_lt_sw) begin
               cmd.op   = OP_CH_WRAP;
               state_in = status.next_ok ? ST_CH_WRITE : ST_NO_SPACE;
            end
         end
         ST_CH_WRITE: begin
            if (status.out_free) begin
               cmd.op   = OP_CH_WRITE;
               state_in = status.wide ? ST_CH_PAD : ST_IDLE;
            end
         end
         ST_CH_PAD: begin
            if (status.out_free) begin
               cmd.op   = OP_CH_PAD;
               state_in = ST_IDLE;
            end
         end
         ST_NO_SPACE: begin
            if (status.out_free) begin
               cmd.op   = OP_NO_SPACE;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[design/tgcl_datapath.sv]
// Datapath of the text grid cell layout block: registers, position state and result register.
`default_nettype none

module tgcl_datapath import tgcl_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   input  wire req_type               req_data,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output rsp_type                    rsp_data,
   input  wire cmd_type               cmd,
   output status_type                 status
);

   logic [TW_W-1:0]      tab_width_ff;
   logic [COL_W-1:0]     screen_width_ff;
   logic [SH_W-1:0]      screen_height_ff;
   logic [TW_W-1:0]      tw_c;
   logic [COL_W-1:0]     sw_c;
   logic [SH_W-1:0]      sh_c;

   req_type              item_ff;
   logic [ROW_W-1:0]     row_ff;
   logic [COL_W-1:0]     col_ff;
   logic [LINE_W-1:0]    line_ff;
   logic [COL_W-1:0]     used_cols_ff;
   logic [UBYTES_W-1:0]  used_bytes_ff;
   logic                 full_ff;
   logic [TW_W-1:0]      rem_ff;
   logic [MCNT_W-1:0]    mod_cnt_ff;
   logic [TIDX_W-1:0]    tab_idx_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   logic [7:0]           b0;
   logic                 is_ctrl;
   logic [GLYPH_W-1:0]   ch_glyph;
   logic [NBYTE_W-1:0]   ch_bytes;
   logic [DW_W-1:0]      ch_dw;
   logic [DW_W-1:0]      ch_need;
   logic [SH_W-1:0]      row_p1;
   logic                 next_ok;
   logic                 col_ge_sw;
   logic                 wrap_fail;
   logic [COL_W:0]       col_p1;
   logic [ROW_W-1:0]     eff_row;
   logic [COL_W-1:0]     eff_col;
   logic [COL_W:0]       eff_col_p1;
   logic [COL_W-1:0]     base_cols;
   logic [UBYTES_W-1:0]  base_bytes;
   logic [DW_W-1:0]      add_cols;
   logic [NBYTE_W-1:0]   add_bytes;
   logic [NBYTE_W-1:0]   tab_bytes;
   logic [COL_W:0]       sum_cols;
   logic [UBYTES_W:0]    sum_bytes;
   logic [COL_W-1:0]     new_cols;
   logic [UBYTES_W-1:0]  new_bytes;
   logic [TW_W:0]        mod_trial;
   logic [TW_W-1:0]      rem_in;
   logic [TW_W-1:0]      tab_count;
   logic                 tab_last;
   logic                 no_space;
   logic                 emit;
   logic                 out_free;
   rsp_type              res;

   // Size registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         tab_width_ff     <= TAB_WIDTH_RESET;
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TAB_WIDTH:     tab_width_ff     <= csr_write_data[TW_W-1:0];
            CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_write_data[COL_W-1:0];
            CSR_SCREEN_HEIGHT: screen_height_ff <= csr_write_data[SH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      tw_c = (tab_width_ff == '0) ? TW_W'(1) :
             (tab_width_ff > TW_W'(MAX_TAB)) ? TW_W'(MAX_TAB) : tab_width_ff;
      sw_c = (screen_width_ff == '0) ? COL_W'(1) :
             (screen_width_ff > COL_W'(MAX_COLS)) ? COL_W'(MAX_COLS) : screen_width_ff;
      sh_c = (screen_height_ff == '0) ? SH_W'(1) :
             (screen_height_ff > SH_W'(MAX_ROWS)) ? SH_W'(MAX_ROWS) : screen_height_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_data;
      end
   end

   // Character classification; control bytes become a caret pair.
   always_comb begin
      b0       = item_ff.glyph[7:0];
      is_ctrl  = (b0 < CHAR_SPACE) || (b0 == CHAR_DEL);
      ch_glyph = is_ctrl ? {16'd0, 8'(b0 + CTRL_OFFSET), CHAR_CARET} : item_ff.glyph;
      ch_bytes = is_ctrl ? NBYTE_W'(1) : item_ff.byte_count;
      if (is_ctrl || item_ff.display_width == 2'd3) begin
         ch_dw = 2'd2;
      end else begin
         ch_dw = item_ff.display_width;
      end
      ch_need = (ch_dw == '0) ? 2'd1 : ch_dw;
   end

   // Position arithmetic.
   always_comb begin
      row_p1     = {1'b0, row_ff} + SH_W'(1);
      next_ok    = row_p1 < sh_c;
      col_ge_sw  = col_ff >= sw_c;
      wrap_fail  = col_ge_sw && !next_ok;
      col_p1     = {1'b0, col_ff} + (COL_W+1)'(1);
      eff_row    = col_ge_sw ? row_p1[ROW_W-1:0] : row_ff;
      eff_col    = col_ge_sw ? '0 : col_ff;
      eff_col_p1 = {1'b0, eff_col} + (COL_W+1)'(1);
      base_cols  = col_ge_sw ? '0 : used_cols_ff;
      base_bytes = col_ge_sw ? '0 : used_bytes_ff;
      tab_bytes  = (tab_idx_ff == '0) ? item_ff.byte_count : '0;
      case (cmd.op)
         OP_TAB_CELL: begin
            add_cols  = 2'd1;
            add_bytes = tab_bytes;
         end
         OP_NL_WRITE: begin
            add_cols  = 2'd1;
            add_bytes = item_ff.byte_count;
         end
         default: begin
            add_cols  = ch_dw;
            add_bytes = ch_bytes;
         end
      endcase
      sum_cols  = {1'b0, base_cols} + (COL_W+1)'(add_cols);
      new_cols  = (sum_cols > (COL_W+1)'(MAX_COLS)) ? COL_W'(MAX_COLS) : sum_cols[COL_W-1:0];
      sum_bytes = {1'b0, base_bytes} + (UBYTES_W+1)'(add_bytes);
      new_bytes = (sum_bytes > {1'b0, BYTES_MAX}) ? BYTES_MAX : sum_bytes[UBYTES_W-1:0];
   end

   // Restoring remainder of the column by the tab width, one bit per cycle.
   always_comb begin
      mod_trial = {rem_ff, col_ff[mod_cnt_ff]};
      if (mod_trial >= {1'b0, tw_c}) begin
         rem_in = TW_W'(mod_trial - {1'b0, tw_c});
      end else begin
         rem_in = mod_trial[TW_W-1:0];
      end
      tab_count = tw_c - rem_ff;
      tab_last  = (TW_W'(tab_idx_ff) + TW_W'(1)) == tab_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff     <= '0;
         mod_cnt_ff <= '0;
         tab_idx_ff <= '0;
      end else begin
         case (cmd.op)
            OP_MOD_INIT: begin
               rem_ff     <= '0;
               mod_cnt_ff <= MCNT_W'(COL_W - 1);
               tab_idx_ff <= '0;
            end
            OP_MOD_STEP: begin
               rem_ff     <= rem_in;
               mod_cnt_ff <= mod_cnt_ff - MCNT_W'(1);
            end
            OP_TAB_CELL: begin
               tab_idx_ff <= tab_idx_ff + TIDX_W'(1);
            end
            default: ;
         endcase
      end
   end

   // Result of the current operation.
   always_comb begin
      res                  = '0;
      res.action           = ACT_WRITE;
      res.row              = row_ff;
      res.column           = col_ff[COLUMN_W-1:0];
      res.row_line_number  = line_ff;
      res.row_used_columns = used_cols_ff;
      res.row_used_bytes   = used_bytes_ff;
      emit                 = 1'b0;
      no_space             = 1'b0;
      case (cmd.op)
         OP_NO_SPACE: begin
            emit     = 1'b1;
            no_space = 1'b1;
         end
         OP_TAB_CELL: begin
            emit                 = 1'b1;
            no_space             = wrap_fail;
            res.row              = eff_row;
            res.column           = eff_col[COLUMN_W-1:0];
            res.cell_glyph       = {24'd0, CHAR_SPACE};
            res.cell_bytes       = tab_bytes;
            res.cell_columns     = 2'd1;
            res.tab_cell         = 1'b1;
            res.cell_attribute   = item_ff.attribute;
            res.row_used_columns = new_cols;
            res.row_used_bytes   = new_bytes;
            res.last             = tab_last;
         end
         OP_NL_WRITE: begin
            emit                 = 1'b1;
            no_space             = wrap_fail;
            res.row              = eff_row;
            res.column           = eff_col[COLUMN_W-1:0];
            res.cell_glyph       = item_ff.glyph;
            res.cell_bytes       = item_ff.byte_count;
            res.cell_columns     = 2'd1;
            res.cell_attribute   = item_ff.attribute;
            res.row_used_columns = new_cols;
            res.row_used_bytes   = new_bytes;
            res.last             = !(eff_col_p1 < {1'b0, sw_c});
         end
         OP_NL_END: begin
            emit       = col_p1 < {1'b0, sw_c};
            res.action = ACT_CLEAR;
            res.column = col_p1[COLUMN_W-1:0];
            res.last   = 1'b1;
         end
         OP_CH_WRAP: begin
            emit       = !col_ge_sw;
            res.action = ACT_CLEAR;
         end
         OP_CH_WRITE: begin
            emit                 = 1'b1;
            res.cell_glyph       = ch_glyph;
            res.cell_bytes       = ch_bytes;
            res.cell_columns     = ch_dw;
            res.cell_attribute   = item_ff.attribute;
            res.row_used_columns = new_cols;
            res.row_used_bytes   = new_bytes;
            res.last             = (ch_dw != 2'd2);
         end
         OP_CH_PAD: begin
            emit     = 1'b1;
            res.last = 1'b1;
         end
         default: ;
      endcase
      if (no_space) begin
         res                 = '0;
         res.action          = ACT_NO_SPACE;
         res.row_line_number = line_ff;
         res.last            = 1'b1;
      end
   end

   // Position state.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff        <= '0;
         col_ff        <= '0;
         line_ff       <= '0;
         used_cols_ff  <= '0;
         used_bytes_ff <= '0;
         full_ff       <= 1'b0;
      end else begin
         case (cmd.op)
            OP_START: begin
               row_ff        <= '0;
               col_ff        <= '0;
               line_ff       <= item_ff.first_line_number;
               used_cols_ff  <= '0;
               used_bytes_ff <= '0;
               full_ff       <= 1'b0;
            end
            OP_NO_SPACE: begin
               full_ff <= 1'b1;
            end
            OP_TAB_CELL, OP_NL_WRITE: begin
               if (wrap_fail) begin
                  full_ff       <= 1'b1;
                  col_ff        <= '0;
                  used_cols_ff  <= '0;
                  used_bytes_ff <= '0;
               end else begin
                  row_ff        <= eff_row;
                  col_ff        <= (cmd.op == OP_TAB_CELL) ? eff_col_p1[COL_W-1:0] : eff_col;
                  used_cols_ff  <= new_cols;
                  used_bytes_ff <= new_bytes;
               end
            end
            OP_NL_END, OP_CH_WRAP: begin
               if (cmd.op == OP_NL_END) begin
                  line_ff <= line_ff + LINE_W'(1);
               end
               col_ff        <= '0;
               used_cols_ff  <= '0;
               used_bytes_ff <= '0;
               if (next_ok) begin
                  row_ff <= row_p1[ROW_W-1:0];
               end else begin
                  full_ff <= 1'b1;
               end
            end
            OP_CH_WRITE: begin
               col_ff        <= col_p1[COL_W-1:0];
               used_cols_ff  <= new_cols;
               used_bytes_ff <= new_bytes;
            end
            OP_CH_PAD: begin
               col_ff <= col_p1[COL_W-1:0];
            end
            default: ;
         endcase
      end
   end

   // Result register.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      status.kind      = item_ff.kind;
      status.full_cond = full_ff || ({1'b0, row_ff} >= sh_c);
      status.is_tab    = (b0 == CHAR_TAB);
      status.is_nl     = (b0 == CHAR_NEWLINE);
      status.fits      = ({1'b0, col_ff} + (COL_W+1)'(ch_need)) <= {1'b0, sw_c};
      status.col_lt_sw = !col_ge_sw;
      status.next_ok   = next_ok;
      status.wrap_fail = wrap_fail;
      status.tab_last  = tab_last;
      status.mod_last  = (mod_cnt_ff == '0);
      status.nl_clear  = col_p1 < {1'b0, sw_c};
      status.wide      = (ch_dw == 2'd2);
      status.out_free  = out_free;
   end

endmodule

`default_nettype wire

[design/text_grid_cell_layout.sv]
// Top level of the text grid cell layout block: controller, datapath and channel wiring.
// A request is taken while the controller is idle and checked in the next cycle, where
// a start or a full-grid report ends. A character takes a wrap, a write and, if wide,
// a pad step; a newline a write and an end step; a tab remainder steps, then one per cell.
// One result leaves per cycle; a stalled result register holds the sequence back.
// Reset is synchronous and active high; it restores the size registers to 8, 80 and 24.
`default_nettype none

module text_grid_cell_layout import tgcl_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   tgcl_req_if.sink                   req_if,
   tgcl_rsp_if.source                 rsp_if,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   // The controller walks each request through its steps; the datapath holds the
   // position state, does the arithmetic and owns the result register.
   cmd_type    cmd;
   status_type status;
   req_type    req_data;
   rsp_type    rsp_data;
   logic       rsp_valid;
   logic       req_ready;

   // Gather the request fields; the datapath keeps a copy on acceptance.
   always_comb begin
      req_data.kind              = req_if.kind;
      req_data.first_line_number = req_if.first_line_number;
      req_data.glyph             = req_if.glyph;
      req_data.byte_count        = req_if.byte_count;
      req_data.display_width     = req_if.display_width;
      req_data.attribute         = req_if.attribute;
   end

   tgcl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tgcl_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .rsp_ready        (rsp_if.ready),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data),
      .cmd              (cmd),
      .status           (status)
   );

   // The request side is open only while the controller is idle. The result register
   // lets the last result of one request wait while the next request is taken.
   assign req_if.ready = req_ready;

   always_comb begin
      rsp_if.valid            = rsp_valid;
      rsp_if.action           = rsp_data.action;
      rsp_if.row              = rsp_data.row;
      rsp_if.column           = rsp_data.column;
      rsp_if.cell_glyph       = rsp_data.cell_glyph;
      rsp_if.cell_bytes       = rsp_data.cell_bytes;
      rsp_if.cell_columns     = rsp_data.cell_columns;
      rsp_if.tab_cell         = rsp_data.tab_cell;
      rsp_if.cell_attribute   = rsp_data.cell_attribute;
      rsp_if.row_line_number  = rsp_data.row_line_number;
      rsp_if.row_used_columns = rsp_data.row_used_columns;
      rsp_if.row_used_bytes   = rsp_data.row_used_bytes;
      rsp_if.last             = rsp_data.last;
   end

endmodule

`default_nettype wire
